@@ design/sct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and constants for the scope capture trigger.
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int BUFFER_DEPTH = 512;
  localparam int IDX_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int STORE_IDX_W  = 9;
  localparam int CNT_W        = 17;
  localparam int SAMPLE_W     = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 3;

  localparam logic [IDX_W-1:0]       DEPTH_IDX  = IDX_W'(BUFFER_DEPTH);
  localparam logic [STORE_IDX_W-1:0] LAST_SLOT  = STORE_IDX_W'(BUFFER_DEPTH - 1);

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DECIMATION = 3'd0,
    REG_LEVEL      = 3'd1,
    REG_HYSTERESIS = 3'd2,
    REG_HOLDOFF    = 3'd3,
    REG_XY_MODE    = 3'd4
  } cfg_reg_t;

  // Schmitt trigger state
  typedef enum logic [2:0] {
    SCH_UNDECIDED = 3'b001,
    SCH_LOW       = 3'b010,
    SCH_HIGH      = 3'b100
  } schmitt_t;

  typedef struct packed {
    logic                       stored;
    logic [STORE_IDX_W-1:0]     store_index;
    logic signed [SAMPLE_W-1:0] stored_x;
    logic signed [SAMPLE_W-1:0] stored_y;
    logic                       last;
    logic                       waiting;
    logic                       rearmed;
  } result_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] level;
    logic [14:0]                hysteresis;
  } trig_cfg_t;

endpackage

@@ design/sct_sample_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_sample_if
// Valid/ready channel carrying one X/Y sample pair per beat.
// ----------------------------------------------------------------------------
interface sct_sample_if;
  logic                                        valid;
  logic                                        ready;
  logic signed [sct_pkg::SAMPLE_W-1:0]         sample_x;
  logic signed [sct_pkg::SAMPLE_W-1:0]         sample_y;

  modport source (output valid, output sample_x, output sample_y, input ready);
  modport sink   (input valid, input sample_x, input sample_y, output ready);
endinterface

@@ design/sct_result_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_result_if
// Valid/ready channel carrying one capture result per beat.
// ----------------------------------------------------------------------------
interface sct_result_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    stored;
  logic [sct_pkg::STORE_IDX_W-1:0]         store_index;
  logic signed [sct_pkg::SAMPLE_W-1:0]     stored_x;
  logic signed [sct_pkg::SAMPLE_W-1:0]     stored_y;
  logic                                    last;
  logic                                    waiting;
  logic                                    rearmed;

  modport source (output valid, output stored, output store_index, output stored_x,
                  output stored_y, output last, output waiting, output rearmed,
                  input ready);
  modport sink   (input valid, input stored, input store_index, input stored_x,
                  input stored_y, input last, input waiting, input rearmed,
                  output ready);
endinterface

@@ design/scope_capture_trigger_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scope_capture_trigger_core
// Decimating triggered capture controller for a two-channel scope.
// ----------------------------------------------------------------------------
// Takes one sample pair per clock and returns one result beat per pair,
// registered in the cycle after acceptance. All counters, the Schmitt compare
// and the re-arm decision settle combinationally ahead of the result register,
// so the sustained rate is one pair per clock; sample.ready drops only while the
// result register holds a beat that the sink has not taken.
module scope_capture_trigger_core (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [sct_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  logic [sct_pkg::CFG_DATA_W-1:0]          cfg_data,
  sct_sample_if.sink                              sample,
  sct_result_if.source                            result
);

  // configuration
  logic [15:0]                decimation_count;
  sct_pkg::trig_cfg_t         trig;
  logic [15:0]                holdoff_ticks;
  logic                       xy_mode;

  // capture state
  logic [sct_pkg::IDX_W-1:0]  capture_index;
  logic                       buffer_full;
  logic [sct_pkg::CNT_W-1:0]  sample_counter;
  sct_pkg::schmitt_t          schmitt_state;

  logic [sct_pkg::IDX_W-1:0]  capture_index_next;
  logic                       buffer_full_next;
  logic [sct_pkg::CNT_W-1:0]  sample_counter_next;
  sct_pkg::schmitt_t          schmitt_state_next;

  sct_pkg::result_t           res;
  sct_pkg::result_t           res_next;
  logic                       res_valid;

  logic                       accept;
  logic [sct_pkg::CNT_W-1:0]  cnt_inc;
  logic [sct_pkg::IDX_W-1:0]  idx_inc;
  logic                       store_now;
  logic                       fill_now;
  logic [sct_pkg::CNT_W-1:0]  cnt_mid;
  logic [sct_pkg::CNT_W-1:0]  wait_cnt;
  logic                       full_mid;
  logic                       fired;
  sct_pkg::schmitt_t          sch_after;
  logic                       rearm;

  assign sample.ready = !res_valid || result.ready;
  assign accept       = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      decimation_count <= 16'd689;
      trig.level       <= '0;
      trig.hysteresis  <= 15'd328;
      holdoff_ticks    <= 16'd4410;
      xy_mode          <= 1'b0;
    end else if (cfg_we) begin
      case (sct_pkg::cfg_reg_t'(cfg_index))
        sct_pkg::REG_DECIMATION: decimation_count <= cfg_data;
        sct_pkg::REG_LEVEL:      trig.level       <= $signed(cfg_data);
        sct_pkg::REG_HYSTERESIS: trig.hysteresis  <= cfg_data[14:0];
        sct_pkg::REG_HOLDOFF:    holdoff_ticks    <= cfg_data;
        sct_pkg::REG_XY_MODE:    xy_mode          <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // capture phase: decimate and store
  assign cnt_inc   = sample_counter + 1'b1;
  assign idx_inc   = capture_index + 1'b1;
  assign store_now = !buffer_full && (cnt_inc > {1'b0, decimation_count});
  assign fill_now  = store_now && (idx_inc >= sct_pkg::DEPTH_IDX);
  assign full_mid  = buffer_full || fill_now;
  assign cnt_mid   = buffer_full ? sample_counter : (store_now ? '0 : cnt_inc);

  // wait phase: Schmitt trigger and holdoff
  assign wait_cnt  = cnt_mid + 1'b1;

  sct_schmitt u_schmitt (
    .state      (schmitt_state),
    .restart    (cnt_mid == '0),
    .x          (sample.sample_x),
    .trig       (trig),
    .state_next (sch_after),
    .fired      (fired)
  );

  assign rearm = full_mid &&
                 (xy_mode || fired || (wait_cnt >= {1'b0, holdoff_ticks}));

  always_comb begin
    capture_index_next  = store_now ? idx_inc : capture_index;
    buffer_full_next    = full_mid;
    sample_counter_next = cnt_mid;
    schmitt_state_next  = schmitt_state;
    if (full_mid && !xy_mode) begin
      sample_counter_next = wait_cnt;
      schmitt_state_next  = sch_after;
    end
    if (rearm) begin
      capture_index_next  = '0;
      sample_counter_next = '0;
      buffer_full_next    = 1'b0;
    end

    res_next.stored      = store_now;
    res_next.store_index = store_now ? capture_index[sct_pkg::STORE_IDX_W-1:0] : '0;
    res_next.stored_x    = store_now ? sample.sample_x : '0;
    res_next.stored_y    = store_now ? sample.sample_y : '0;
    res_next.last        = fill_now;
    res_next.waiting     = buffer_full_next;
    res_next.rearmed     = rearm;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_index  <= '0;
      buffer_full    <= 1'b0;
      sample_counter <= '0;
      schmitt_state  <= sct_pkg::SCH_UNDECIDED;
      res_valid      <= 1'b0;
    end else begin
      if (accept) begin
        capture_index  <= capture_index_next;
        buffer_full    <= buffer_full_next;
        sample_counter <= sample_counter_next;
        schmitt_state  <= schmitt_state_next;
        res_valid      <= 1'b1;
      end else if (result.ready) begin
        res_valid      <= 1'b0;
      end
    end
  end

  // hold the beat until taken
  always_ff @(posedge clk) begin
    if (accept) res <= res_next;
  end

  assign result.valid       = res_valid;
  assign result.stored      = res.stored;
  assign result.store_index = res.store_index;
  assign result.stored_x    = res.stored_x;
  assign result.stored_y    = res.stored_y;
  assign result.last        = res.last;
  assign result.waiting     = res.waiting;
  assign result.rearmed     = res.rearmed;

  a_full_matches_index: assert property (@(posedge clk) disable iff (rst)
    buffer_full == (capture_index == sct_pkg::DEPTH_IDX))
    else $error("buffer_full out of step with capture_index");

  a_last_is_final_slot: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.last) |->
      (result.stored && result.store_index == sct_pkg::LAST_SLOT))
    else $error("last without a store to the final slot");

  a_no_store_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.stored) |->
      (result.store_index == '0 && result.stored_x == '0 &&
       result.stored_y == '0 && !result.last))
    else $error("unstored result carries data");

  a_rearm_not_waiting: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.rearmed) |-> !result.waiting)
    else $error("re-armed result still reports waiting");

  a_accept_moves_state: assert property (@(posedge clk) disable iff (rst)
    !accept |=> ($stable(capture_index) && $stable(sample_counter)))
    else $error("capture state moved without an accepted sample");

endmodule

@@ design/sct_schmitt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_schmitt
// Next-state logic of the Schmitt trigger on X, with fire on low-to-high.
// ----------------------------------------------------------------------------
module sct_schmitt (
  input  sct_pkg::schmitt_t                    state,
  input  logic                                 restart,
  input  logic signed [sct_pkg::SAMPLE_W-1:0]  x,
  input  sct_pkg::trig_cfg_t                   trig,
  output sct_pkg::schmitt_t                    state_next,
  output logic                                 fired
);

  logic signed [sct_pkg::SAMPLE_W+1:0] lo;
  logic signed [sct_pkg::SAMPLE_W+1:0] x_ext;
  logic                                at_hi;
  logic                                at_lo;
  sct_pkg::schmitt_t                   cur;

  assign lo    = (sct_pkg::SAMPLE_W+2)'(trig.level)
               - $signed({3'b000, trig.hysteresis});
  assign x_ext = (sct_pkg::SAMPLE_W+2)'(x);
  assign at_hi = x >= trig.level;
  assign at_lo = x_ext <= lo;
  // the wait starts from the undecided state
  assign cur   = restart ? sct_pkg::SCH_UNDECIDED : state;

  always_comb begin
    state_next = cur;
    fired      = 1'b0;
    case (cur)
      sct_pkg::SCH_LOW: begin
        if (at_hi) begin
          state_next = sct_pkg::SCH_HIGH;
          fired      = 1'b1;
        end
      end
      sct_pkg::SCH_HIGH: begin
        if (at_lo) state_next = sct_pkg::SCH_LOW;
      end
      default: begin
        if (at_hi)      state_next = sct_pkg::SCH_HIGH;
        else if (at_lo) state_next = sct_pkg::SCH_LOW;
      end
    endcase
  end

endmodule
